@@ src/page_frame_table_lru_assert.svh @@
// Assertion macros for the page frame table.
// Depends on nothing; included by the modules that check themselves.
`ifndef PAGE_FRAME_TABLE_LRU_ASSERT_SVH
`define PAGE_FRAME_TABLE_LRU_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PFT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PFT_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PFT_ASSERT(label, clk, rst, prop, msg)
`define PFT_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

@@ src/pft_pkg.sv @@
// Shared types and constants of the page frame table.
// Used by the controller, datapath and top level.
package pft_pkg;
  localparam int Frames = 16;
  localparam int FrameW = (Frames > 1) ? $clog2(Frames) : 1;
  localparam int CntW = $clog2(Frames + 1);
  localparam int MaxRes = 16;

  localparam logic [2:0] CMD_FETCH = 3'd0;
  localparam logic [2:0] CMD_NEW = 3'd1;
  localparam logic [2:0] CMD_UNPIN = 3'd2;
  localparam logic [2:0] CMD_FLUSH = 3'd3;
  localparam logic [2:0] CMD_FLUSH_ALL = 3'd4;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_UNKNOWN = 3'd1;
  localparam logic [2:0] ST_PIN_ZERO = 3'd2;
  localparam logic [2:0] ST_NO_VICTIM = 3'd3;
  localparam logic [2:0] ST_PIN_OVF = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_EXEC, S_SWEEP, S_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic scan_step;
    logic exec;
    logic sweep_step;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic sweep_done;
    logic sweep_emit;
    logic sweep_last;
  } stat_t;

  typedef struct packed {
    logic [2:0] status;
    logic hit;
    logic [3:0] frame_no;
    logic read_needed;
    logic zero_fill;
    logic writeback_valid;
    logic [31:0] writeback_page;
    logic last;
  } result_t;
endpackage

@@ src/pft_ctrl.sv @@
// Controller of the page frame table: sequences lookup, update and sweep.
// Depends on pft_pkg and the assertion header.
`include "page_frame_table_lru_assert.svh"
module pft_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  logic [2:0] command,
  input  logic out_free,
  input  pft_pkg::stat_t stat,
  output pft_pkg::cmd_t cmd,
  output logic in_ready,
  output logic out_load
);
  pft_pkg::state_t state, state_next;
  logic is_all;
  logic is_all_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pft_pkg::S_IDLE;
      is_all <= 1'b0;
    end else begin
      state <= state_next;
      is_all <= is_all_next;
    end
  end

  always_comb begin
    state_next = state;
    is_all_next = is_all;
    case (state)
      pft_pkg::S_IDLE: begin
        if (in_fire) begin
          state_next = pft_pkg::S_SCAN;
          is_all_next = (command == pft_pkg::CMD_FLUSH_ALL);
        end
      end
      pft_pkg::S_SCAN: begin
        if (stat.scan_done) state_next = is_all ? pft_pkg::S_SWEEP : pft_pkg::S_EXEC;
      end
      pft_pkg::S_EXEC: begin
        if (out_free) state_next = pft_pkg::S_IDLE;
      end
      pft_pkg::S_SWEEP: begin
        if (stat.sweep_done) state_next = pft_pkg::S_OUT;
        else if (stat.sweep_emit && out_free && stat.sweep_last) state_next = pft_pkg::S_IDLE;
      end
      pft_pkg::S_OUT: begin
        if (out_free) state_next = pft_pkg::S_IDLE;
      end
      default: state_next = pft_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_load = 1'b0;
    case (state)
      pft_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.capture = in_fire;
      end
      pft_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      pft_pkg::S_EXEC: begin
        cmd.exec = out_free;
        out_load = out_free;
      end
      pft_pkg::S_SWEEP: begin
        if (!stat.sweep_done) begin
          if (stat.sweep_emit) begin
            cmd.sweep_step = out_free;
            out_load = out_free;
          end else begin
            cmd.sweep_step = 1'b1;
          end
        end
      end
      pft_pkg::S_OUT: out_load = out_free;
      default: ;
    endcase
  end

  `PFT_ASSERT(a_ready_idle, clk, rst, in_ready |-> (state == pft_pkg::S_IDLE), "ready off idle")
  `PFT_ASSERT(a_cap, clk, rst, in_fire |=> (state == pft_pkg::S_SCAN), "no scan after accept")
  `PFT_ASSERT(a_load, clk, rst, out_load |-> out_free, "load while output busy")
endmodule

@@ src/pft_data.sv @@
// Datapath of the page frame table: frame arrays, serial scan and updates.
// Depends on pft_pkg and the assertion header.
`include "page_frame_table_lru_assert.svh"
module pft_data (
  input  logic clk,
  input  logic rst,
  input  pft_pkg::cmd_t cmd,
  input  logic [2:0] command,
  input  logic [31:0] page_id,
  input  logic mark_dirty,
  output pft_pkg::stat_t stat,
  output pft_pkg::result_t res
);
  localparam int F = pft_pkg::Frames;
  localparam int FW = pft_pkg::FrameW;
  localparam int CW = pft_pkg::CntW;

  logic [31:0] slot_page [F];
  logic [F-1:0] slot_used;
  logic [F-1:0] slot_modified;
  logic [15:0] slot_pins [F];
  logic [63:0] slot_stamp [F];
  logic [63:0] use_clock;

  logic [2:0] c_cmd;
  logic [31:0] c_pid;
  logic c_md;
  logic [CW-1:0] idx;
  logic found;
  logic [FW-1:0] found_f;
  logic have_free;
  logic [FW-1:0] free_f;
  logic have_lru;
  logic [FW-1:0] lru_f;
  logic [63:0] lru_stamp;
  logic [CW-1:0] nres;
  logic [FW-1:0] ix;
  logic [FW-1:0] vf;

  assign ix = idx[FW-1:0];
  assign vf = have_free ? free_f : lru_f;

  // Sweep ends early once the result cap is reached or no dirty frame is left above.
  always_comb begin
    logic more;
    more = 1'b0;
    for (int j = 0; j < F; j++)
      if (CW'(j) > idx && slot_used[j] && slot_modified[j]) more = 1'b1;
    stat.scan_done = (idx == CW'(F - 1));
    stat.sweep_done = (idx == CW'(F));
    stat.sweep_emit = !stat.sweep_done && slot_used[ix] && slot_modified[ix];
    stat.sweep_last = !more || (nres == CW'(pft_pkg::MaxRes - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used <= '0;
      slot_modified <= '0;
      use_clock <= 64'd1;
      idx <= '0;
      nres <= '0;
      for (int j = 0; j < F; j++) begin
        slot_page[j] <= '0;
        slot_pins[j] <= '0;
        slot_stamp[j] <= '0;
      end
    end else begin
      if (cmd.capture) begin
        c_cmd <= command;
        c_pid <= page_id;
        c_md <= mark_dirty;
        idx <= '0;
        found <= 1'b0;
        have_free <= 1'b0;
        have_lru <= 1'b0;
        found_f <= '0;
        free_f <= '0;
        lru_f <= '0;
        lru_stamp <= '0;
      end
      if (cmd.scan_step) begin
        if (!found && slot_used[ix] && slot_page[ix] == c_pid) begin
          found <= 1'b1;
          found_f <= ix;
        end
        if (!have_free && !slot_used[ix]) begin
          have_free <= 1'b1;
          free_f <= ix;
        end
        if (slot_pins[ix] == 16'd0 && (!have_lru || slot_stamp[ix] < lru_stamp)) begin
          have_lru <= 1'b1;
          lru_f <= ix;
          lru_stamp <= slot_stamp[ix];
        end
        idx <= stat.scan_done ? '0 : idx + 1'b1;
        nres <= '0;
      end
      if (cmd.sweep_step) begin
        if (stat.sweep_emit) begin
          slot_modified[ix] <= 1'b0;
          nres <= nres + 1'b1;
          if (stat.sweep_last) idx <= CW'(F);
          else idx <= idx + 1'b1;
        end else begin
          idx <= idx + 1'b1;
        end
      end
      if (cmd.exec) begin
        case (c_cmd)
          pft_pkg::CMD_FETCH, pft_pkg::CMD_NEW: begin
            if (found) begin
              if (slot_pins[found_f] != 16'hFFFF) begin
                slot_pins[found_f] <= slot_pins[found_f] + 16'd1;
                if (c_cmd == pft_pkg::CMD_NEW) begin
                  slot_modified[found_f] <= 1'b1;
                  slot_stamp[found_f] <= use_clock + 64'd2;
                  use_clock <= use_clock + 64'd3;
                end else begin
                  slot_stamp[found_f] <= use_clock;
                  use_clock <= use_clock + 64'd1;
                end
              end
            end else if (have_free || have_lru) begin
              slot_page[vf] <= c_pid;
              slot_used[vf] <= 1'b1;
              slot_modified[vf] <= (c_cmd == pft_pkg::CMD_NEW);
              slot_pins[vf] <= 16'd1;
              if (c_cmd == pft_pkg::CMD_NEW) begin
                slot_stamp[vf] <= use_clock + 64'd2;
                use_clock <= use_clock + 64'd3;
              end else begin
                slot_stamp[vf] <= use_clock;
                use_clock <= use_clock + 64'd1;
              end
            end
          end
          pft_pkg::CMD_UNPIN: begin
            if (found && slot_pins[found_f] != 16'd0) begin
              slot_pins[found_f] <= slot_pins[found_f] - 16'd1;
              slot_modified[found_f] <= slot_modified[found_f] | c_md;
              slot_stamp[found_f] <= use_clock;
              use_clock <= use_clock + 64'd1;
            end
          end
          pft_pkg::CMD_FLUSH: begin
            if (found) slot_modified[found_f] <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    res = '0;
    res.last = 1'b1;
    if (c_cmd == pft_pkg::CMD_FLUSH_ALL) begin
      if (stat.sweep_emit) begin
        res.hit = 1'b1;
        res.frame_no = 4'(ix);
        res.writeback_valid = 1'b1;
        res.writeback_page = slot_page[ix];
        res.last = stat.sweep_last;
      end
    end else begin
      case (c_cmd)
        pft_pkg::CMD_FETCH, pft_pkg::CMD_NEW: begin
          if (found) begin
            res.hit = 1'b1;
            res.frame_no = 4'(found_f);
            if (slot_pins[found_f] == 16'hFFFF) res.status = pft_pkg::ST_PIN_OVF;
            else res.zero_fill = (c_cmd == pft_pkg::CMD_NEW);
          end else if (have_free || have_lru) begin
            res.frame_no = 4'(vf);
            res.read_needed = (c_cmd == pft_pkg::CMD_FETCH);
            res.zero_fill = (c_cmd == pft_pkg::CMD_NEW);
            if (slot_used[vf] && slot_modified[vf]) begin
              res.writeback_valid = 1'b1;
              res.writeback_page = slot_page[vf];
            end
          end else begin
            res.status = pft_pkg::ST_NO_VICTIM;
          end
        end
        pft_pkg::CMD_UNPIN: begin
          if (!found) res.status = pft_pkg::ST_UNKNOWN;
          else begin
            res.hit = 1'b1;
            res.frame_no = 4'(found_f);
            if (slot_pins[found_f] == 16'd0) res.status = pft_pkg::ST_PIN_ZERO;
          end
        end
        pft_pkg::CMD_FLUSH: begin
          if (found) begin
            res.hit = 1'b1;
            res.frame_no = 4'(found_f);
            if (slot_modified[found_f]) begin
              res.writeback_valid = 1'b1;
              res.writeback_page = slot_page[found_f];
            end
          end
        end
        default: ;
      endcase
    end
  end

  `PFT_ASSERT(a_scan_sweep, clk, rst, !(cmd.scan_step && cmd.sweep_step), "scan and sweep overlap")
  `PFT_ASSERT(a_exec_scan, clk, rst, !(cmd.exec && cmd.scan_step), "exec during scan")
  `PFT_ASSERT(a_cap_only, clk, rst, cmd.capture |-> !(cmd.exec || cmd.sweep_step), "capture mixes")
endmodule

@@ src/page_frame_table_lru.sv @@
// Top level of the page frame table with LRU replacement.
// Depends on pft_pkg, pft_ctrl, pft_data and the assertion header.
//
// A frame table for a buffer pool of 16 frames: each command beat names a page and
// returns one result beat (flush_all returns one beat per dirty frame, up to 16,
// or one empty beat). The block takes one command at a time: a command is captured
// in the cycle it is accepted, then runs a serial scan that finds the page, the
// lowest free frame and the least recently used unpinned frame one frame per cycle,
// then updates the table and posts its result. flush_all instead sweeps the
// frames after the scan, one per cycle while no beat waits on the output
// register, and stops at the last dirty frame.
// Results sit in an output register; a command whose result is ready waits while the
// previous beat is still held there, and each flush_all beat waits the same way.
// Page data never passes through the block; the host acts on read_needed,
// zero_fill and writeback_valid.
`include "page_frame_table_lru_assert.svh"
module page_frame_table_lru (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [39:0] s_tdata,   // command[2:0], page_id[34:3], mark_dirty[35], zeros
  output logic m_tvalid,
  input  logic m_tready,
  output logic [47:0] m_tdata,   // status[2:0], hit[3], frame_no[7:4], read_needed[8],
                                 // zero_fill[9], writeback_valid[10], writeback_page[42:11]
  output logic m_tlast
);
  pft_pkg::cmd_t cmd;
  pft_pkg::stat_t stat;
  pft_pkg::result_t res;
  pft_pkg::result_t oreg;
  logic in_fire;
  logic out_free;
  logic out_load;

  assign in_fire = s_tvalid && s_tready;
  // The output register is free when empty or drained in this cycle.
  assign out_free = !m_tvalid || m_tready;

  pft_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .command(s_tdata[2:0]),
    .out_free(out_free), .stat(stat), .cmd(cmd), .in_ready(s_tready), .out_load(out_load)
  );

  pft_data u_data (
    .clk(clk), .rst(rst), .cmd(cmd), .command(s_tdata[2:0]), .page_id(s_tdata[34:3]),
    .mark_dirty(s_tdata[35]), .stat(stat), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) oreg <= res;
  end

  assign m_tdata = {5'd0, oreg.writeback_page, oreg.writeback_valid, oreg.zero_fill,
                    oreg.read_needed, oreg.frame_no, oreg.hit, oreg.status};
  assign m_tlast = oreg.last;

  `PFT_ASSERT(a_hold, clk, rst, (m_tvalid && !m_tready) |=> ($stable(m_tdata) && m_tvalid),
    "result changed while stalled")
  `PFT_ASSERT(a_wb, clk, rst, (m_tvalid && !m_tdata[10]) |-> (m_tdata[42:11] == 32'd0),
    "writeback page without writeback")
  `PFT_ASSERT_NR(a_rst, clk, rst |=> !m_tvalid, "valid after reset")
endmodule
